/* hdl/usd_pkg.sv */
// Types and constants shared by the UTF-8 stream decoder.
`timescale 1ns / 1ps

package usd_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned LEN_W = 3;
  localparam int unsigned CNT_W = 3;

  localparam logic [CP_W-1:0]  REPL_CP   = 21'h00FFFD;
  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MIN   = 8'hC0;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD_BAD    = 8'hF8;
  localparam logic [1:0] CONT_TAG    = 2'b10;

  // One run of results caused by a single input word: cnt results, all of
  // them U+FFFD of length one except the final one, which carries cp/len.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
  } run_t;

endpackage

/* hdl/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder: byte decode, run buffer, result output.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------------
//  input   | in        | in_valid / in_stall  | data_byte[7:0], is_last
//  output  | out       | out_valid / out_stall| code_point[20:0], seq_len[2:0],
//          |           |                      | last_of_run
//
// A word is decoded at the edge that accepts it and its run of zero to four
// results is loaded for the output, waiting while a run is still leaving; results
// leave one per cycle while out_stall is low, so one-result words pass back to back.
// A second run register sits behind the output one; in_stall is high only while
// it is full, so it is registered and never follows out_stall combinationally.
// Synchronous active-high reset empties both registers and clears any partial sequence.

module utf8_stream_decoder
  import usd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  is_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CP_W-1:0]       code_point,
  output logic [LEN_W-1:0]      seq_len,
  output logic                  last_of_run
);

  // Sequence state.
  logic [2:0]       need_total, need_total_next;
  logic [1:0]       bytes_seen, bytes_seen_next;
  logic [CP_W-1:0]  accum_point, accum_point_next;

  // Run currently being shown on the output, and the one waiting behind it.
  run_t             run, pend;
  logic             pend_valid;
  run_t             dec;

  logic             in_take;
  logic             run_free;

  // Lead-byte decode.
  logic             lead_res;
  logic [CP_W-1:0]  lead_cp;
  logic [2:0]       lead_need;
  logic [CP_W-1:0]  lead_bits;
  logic             lead_pend;

  logic             is_cont;
  logic [2:0]       seen_inc;
  logic [CP_W-1:0]  acc_shift;

  assign in_stall = pend_valid;
  assign in_take  = in_valid && !pend_valid;

  always_comb begin
    lead_res  = 1'b1;
    lead_cp   = REPL_CP;
    lead_need = 3'd0;
    lead_bits = '0;
    lead_pend = 1'b0;
    if (data_byte < ASCII_LIMIT) begin
      lead_cp = {13'd0, data_byte};
    end else if (data_byte >= LEAD_BAD || data_byte < LEAD2_MIN) begin
      lead_cp = REPL_CP;
    end else begin
      if (data_byte >= LEAD4_MIN) begin
        lead_need = LEN_FOUR;
        lead_bits = {18'd0, data_byte[2:0]};
      end else if (data_byte >= LEAD3_MIN) begin
        lead_need = LEN_THREE;
        lead_bits = {17'd0, data_byte[3:0]};
      end else begin
        lead_need = LEN_TWO;
        lead_bits = {16'd0, data_byte[4:0]};
      end
      // A multi-byte lead that ends the string is cut off at once.
      if (is_last) begin
        lead_cp = REPL_CP;
      end else begin
        lead_res  = 1'b0;
        lead_pend = 1'b1;
      end
    end
  end

  assign is_cont   = (data_byte[7:6] == CONT_TAG);
  assign seen_inc  = {1'b0, bytes_seen} + 3'd1;
  assign acc_shift = {accum_point[CP_W-7:0], data_byte[5:0]};

  // Run descriptor and next sequence state for the word on the input.
  always_comb begin
    dec.cnt          = {2'd0, lead_res};
    dec.cp           = lead_cp;
    dec.len          = LEN_ONE;
    need_total_next  = lead_pend ? lead_need : 3'd0;
    bytes_seen_next  = lead_pend ? 2'd1 : 2'd0;
    accum_point_next = lead_pend ? lead_bits : '0;
    if (need_total != 3'd0) begin
      if (is_cont) begin
        if (seen_inc >= need_total) begin
          dec.cnt          = 3'd1;
          dec.cp           = acc_shift;
          dec.len          = need_total;
          need_total_next  = 3'd0;
          bytes_seen_next  = 2'd0;
          accum_point_next = '0;
        end else if (is_last) begin
          // Every gathered byte, this one included, becomes a replacement.
          dec.cnt          = seen_inc;
          dec.cp           = REPL_CP;
          dec.len          = LEN_ONE;
          need_total_next  = 3'd0;
          bytes_seen_next  = 2'd0;
          accum_point_next = '0;
        end else begin
          dec.cnt          = 3'd0;
          need_total_next  = need_total;
          bytes_seen_next  = seen_inc[1:0];
          accum_point_next = acc_shift;
        end
      end else begin
        // Broken sequence: replacements for what was gathered, then the
        // breaking byte as a fresh lead.
        dec.cnt = {1'b0, bytes_seen} + {2'd0, lead_res};
        if (!lead_res) begin
          dec.cp = REPL_CP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      need_total  <= 3'd0;
      bytes_seen  <= 2'd0;
      accum_point <= '0;
    end else if (in_take) begin
      need_total  <= need_total_next;
      bytes_seen  <= bytes_seen_next;
      accum_point <= accum_point_next;
    end
  end

  // The output run is free when empty or when its final result leaves now.
  assign run_free = (run.cnt == 3'd0) || (run.cnt == 3'd1 && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      run.cnt    <= 3'd0;
      pend_valid <= 1'b0;
    end else begin
      if (run_free) begin
        if (pend_valid) begin
          run        <= pend;
          pend_valid <= 1'b0;
        end else if (in_take) begin
          run <= dec;
        end else begin
          run.cnt <= 3'd0;
        end
      end else if (!out_stall) begin
        run.cnt <= run.cnt - 3'd1;
        if (in_take && dec.cnt != 3'd0) begin
          pend       <= dec;
          pend_valid <= 1'b1;
        end
      end else if (in_take && dec.cnt != 3'd0) begin
        pend       <= dec;
        pend_valid <= 1'b1;
      end
    end
  end

  assign out_valid   = (run.cnt != 3'd0);
  assign last_of_run = (run.cnt == 3'd1);
  assign code_point  = last_of_run ? run.cp : REPL_CP;
  assign seq_len     = last_of_run ? run.len : LEN_ONE;

endmodule

/* tb/utf8_stream_decoder_tb.sv */
// Self-checking testbench for the UTF-8 stream decoder, with a scoreboard class.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;
  import usd_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 7;
  // Longest stretch with no word moving on either channel before the run is
  // declared hung. Gaps at 82 per cent idling stay far shorter than this, so it is
  // many times the slowest correct run.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WORDS_PER_PHASE = 41;

  // Decoding scoreboard: keeps its own copy of the sequence state, works out
  // the code points each accepted byte should give and checks the results
  // against them in order.
  class utf8_scoreboard;
    typedef struct {
      logic [CP_W-1:0]  cp;
      logic [LEN_W-1:0] len;
      logic             fin;
    } point_t;

    point_t           expect_q[$];
    point_t           run_q[$];
    logic [2:0]       need_len;
    logic [2:0]       got_cnt;
    logic [CP_W-1:0]  acc;
    int               errors;

    function new();
      need_len = '0;
      got_cnt  = '0;
      acc      = '0;
      errors   = 0;
    endfunction

    function void add_point(logic [CP_W-1:0] cp, logic [LEN_W-1:0] len);
      point_t p;
      p.cp  = cp;
      p.len = len;
      p.fin = 1'b0;
      run_q.push_back(p);
    endfunction

    // One replacement for every byte of the abandoned sequence.
    function void drop_sequence();
      for (int i = 0; i < got_cnt; i++) add_point(REPL_CP, LEN_ONE);
      need_len = '0;
      got_cnt  = '0;
      acc      = '0;
    endfunction

    function void take_lead(logic [7:0] b, logic l);
      logic [2:0]      want_len;
      logic [CP_W-1:0] bits;
      if (b < ASCII_LIMIT) begin
        add_point({13'd0, b}, LEN_ONE);
        return;
      end
      if (b >= LEAD_BAD || b < LEAD2_MIN) begin
        add_point(REPL_CP, LEN_ONE);
        return;
      end
      if (b >= LEAD4_MIN) begin
        want_len = LEN_FOUR;
        bits     = {18'd0, b[2:0]};
      end else if (b >= LEAD3_MIN) begin
        want_len = LEN_THREE;
        bits     = {17'd0, b[3:0]};
      end else begin
        want_len = LEN_TWO;
        bits     = {16'd0, b[4:0]};
      end
      // A multi-byte lead that ends the string cannot be finished.
      if (l) begin
        add_point(REPL_CP, LEN_ONE);
        return;
      end
      need_len = want_len;
      got_cnt  = 3'd1;
      acc      = bits;
    endfunction

    function void note_byte(logic [7:0] b, logic l);
      run_q.delete();
      if (need_len != 0) begin
        if (b[7:6] == CONT_TAG) begin
          acc     = {acc[CP_W-7:0], b[5:0]};
          got_cnt = got_cnt + 3'd1;
          if (got_cnt >= need_len) begin
            add_point(acc, need_len);
            need_len = '0;
            got_cnt  = '0;
            acc      = '0;
          end else if (l) begin
            drop_sequence();
          end
        end else begin
          drop_sequence();
          take_lead(b, l);
        end
      end else begin
        take_lead(b, l);
      end
      if (run_q.size() > 0) run_q[run_q.size()-1].fin = 1'b1;
      foreach (run_q[i]) expect_q.push_back(run_q[i]);
    endfunction

    function void check_point(logic [CP_W-1:0] cp, logic [LEN_W-1:0] len, logic fin);
      point_t want;
      if (expect_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: cp %06h len %0d last %0b", cp, len, fin);
        return;
      end
      want = expect_q.pop_front();
      if (want.cp !== cp || want.len !== len || want.fin !== fin) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected cp %06h len %0d last %0b, got cp %06h len %0d last %0b",
                   want.cp, want.len, want.fin, cp, len, fin);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       data_byte = 8'h00;
  logic             is_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CP_W-1:0]  code_point;
  logic [LEN_W-1:0] seq_len;
  logic             last_of_run;

  utf8_scoreboard sb = new();

  // Stimulus waiting to be sent: one byte and its end-of-string flag per word.
  logic [7:0] stim_b[$];
  logic       stim_l[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;
  int sent_in_phase;

  int idle_tab[4]  = '{0, 82, 0, 37};
  int stall_tab[4] = '{0, 0, 82, 37};

  utf8_stream_decoder DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .seq_len     (seq_len),
    .last_of_run (last_of_run)
  );

  always #CLK_HALF clk = ~clk;

  // Receiving side: every result accepted at an edge is checked against the
  // oldest expected code point, and the stall for the next cycle is drawn.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_point(code_point, seq_len, last_of_run);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any cycle in which a word moves on either channel resets it.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[utf8_stream_decoder] ERROR");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic l);
    stim_b.push_back(b);
    stim_l.push_back(l);
  endtask

  // Present one word, with a random gap before it, and hold it until the
  // block takes it. The scoreboard learns of the word at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    is_last   <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, l);
  endtask

  task automatic send_all();
    while (stim_b.size() > 0) begin
      send_byte(stim_b.pop_front(), stim_l.pop_front());
      sent_in_phase++;
    end
  endtask

  // One random string: mostly well-formed characters of every length with
  // random payload bits, mixed with stray continuation bytes, invalid leads,
  // cut-off sequences and the odd wholly random byte. The final byte carries
  // the end-of-string flag, and now and then a byte inside the string does.
  task automatic gen_string();
    int         n_chars;
    int         kind;
    int         n_cont;
    logic [7:0] lead;
    n_chars = $urandom_range(1, 8);
    for (int c = 0; c < n_chars; c++) begin
      kind   = $urandom_range(99);
      n_cont = 0;
      if (kind < 22) begin
        lead = {1'b0, 7'($urandom)};
      end else if (kind < 42) begin
        lead   = {3'b110, 5'($urandom)};
        n_cont = 1;
      end else if (kind < 60) begin
        lead   = {4'b1110, 4'($urandom)};
        n_cont = 2;
      end else if (kind < 77) begin
        lead   = {5'b11110, 3'($urandom)};
        n_cont = 3;
      end else if (kind < 83) begin
        lead = {CONT_TAG, 6'($urandom)};
      end else if (kind < 87) begin
        lead = {5'b11111, 3'($urandom)};
      end else if (kind < 95) begin
        // Sequence that stops short of its length.
        n_cont = $urandom_range(0, 1);
        lead   = (n_cont == 0) ? {3'b110, 5'($urandom)} : {4'b1110, 4'($urandom)};
        if ($urandom_range(1)) begin
          lead   = {5'b11110, 3'($urandom)};
          n_cont = $urandom_range(0, 2);
        end
      end else begin
        lead = 8'($urandom);
      end
      add_byte(lead, ($urandom_range(99) < 3));
      for (int k = 0; k < n_cont; k++)
        add_byte({CONT_TAG, 6'($urandom)}, ($urandom_range(99) < 3));
    end
    stim_l[stim_l.size()-1] = 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: field extremes, every sequence length, the largest
    // code point, a stray continuation, invalid leads, a sequence broken by a
    // new lead, one cut off by the end of the string and a lone lead at the
    // end of a string.
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b1);
    add_byte(8'h80, 1'b0);
    add_byte(8'hC2, 1'b0);
    add_byte(8'hA9, 1'b1);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'hAC, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h9F, 1'b0);
    add_byte(8'h98, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hF7, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hF8, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h90, 1'b0);
    add_byte(8'h80, 1'b1);
    add_byte(8'hC3, 1'b1);
    sent_in_phase = 0;
    send_all();

    // Random strings under each idling pattern in turn.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct <= stall_tab[ph];
      sent_in_phase  = 0;
      while (sent_in_phase < WORDS_PER_PHASE) begin
        gen_string();
        send_all();
      end
    end
    in_valid <= 1'b0;

    // Let the output side drain, then keep the clock running so that any surplus
    // result would show up.
    while (sb.expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expect_q.size() == 0) begin
      $display("[utf8_stream_decoder] OK");
    end else begin
      $display("[utf8_stream_decoder] ERROR");
    end
    $finish;
  end

endmodule
